[rtl/whmr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// whmr_pkg
// Shared widths, reset values and register codes for the Walsh-Hadamard
// mask row generator.
// ----------------------------------------------------------------------------
package whmr_pkg;

  localparam int IDX_W     = 16;  // pattern index width
  localparam int ROW_W     = 64;  // row beat width
  localparam int ROW_NUM_W = 6;   // row number width
  localparam int CFG_W     = 3;   // widest config register
  localparam int CFG_IDX_W = 1;   // config register index width

  localparam logic [CFG_W-1:0] CFG_LOG2_RESET = 3'd6;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH_LOG2  = 1'b0,
    CFG_HEIGHT_LOG2 = 1'b1
  } cfg_reg_e;

endpackage
`default_nettype wire

[rtl/whmr_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// whmr_in_if
// Pattern index channel: valid/ready with a 16-bit index payload.
// ----------------------------------------------------------------------------
interface whmr_in_if;
  logic                       valid;
  logic                       ready;
  logic [whmr_pkg::IDX_W-1:0] mask_index;

  modport source (output valid, output mask_index, input ready);
  modport sink   (input valid, input mask_index, output ready);
endinterface
`default_nettype wire

[rtl/whmr_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// whmr_out_if
// Mask row channel: valid/ready with row bits, row number and last flag.
// ----------------------------------------------------------------------------
interface whmr_out_if;
  logic                           valid;
  logic                           ready;
  logic [whmr_pkg::ROW_W-1:0]     row_bits;
  logic [whmr_pkg::ROW_NUM_W-1:0] row_number;
  logic                           last_row;

  modport source (output valid, output row_bits, output row_number,
                  output last_row, input ready);
  modport sink   (input valid, input row_bits, input row_number,
                  input last_row, output ready);
endinterface
`default_nettype wire

[rtl/walsh_hadamard_mask_rows_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// walsh_hadamard_mask_rows_unit
// Sequency-ordered 2D Walsh-Hadamard mask generator, one mask row per beat.
// ----------------------------------------------------------------------------
// Each pattern index accepted on in_i yields 2^height_log2 row beats on out_o,
// rows 0 to height-1 in order, the final one flagged with last_row. The row
// sequencer issues one row per cycle unless out_o back-pressure stalls it,
// 1 to 64 rows per item; the next index is loaded behind the last row of
// the current one, so rows of consecutive items follow without a gap. An
// index is held in s0, then s1; each row is registered in p1 and p2. The low
// width_log2 index bits select the column pattern and the upper bits the row
// pattern; each part is Gray-coded and bit-reversed over its own size. Pixel
// x of row y is 1 when the parity of (revx & x) ^ (revy & y) is even; bits
// at and above the width read 0. Register values above MAX_SIDE_LOG2
// saturate. Write the configuration only while no rows are pending.
// ----------------------------------------------------------------------------
module walsh_hadamard_mask_rows_unit #(
  parameter int MAX_SIDE_LOG2 = 6  // 1..6
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            cfg_we_i,
  input  wire [whmr_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire [whmr_pkg::CFG_W-1:0]      cfg_data_i,
  whmr_in_if.sink                        in_i,
  whmr_out_if.source                     out_o
);

  localparam int SIDE = MAX_SIDE_LOG2;
  localparam int LW   = $clog2(MAX_SIDE_LOG2 + 1);
  localparam logic [LW-1:0] SIDE_L = LW'(MAX_SIDE_LOG2);

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------
  function automatic logic [LW-1:0] clamp_log2(input logic [whmr_pkg::CFG_W-1:0] v);
    logic [LW-1:0] r;
    if (v > whmr_pkg::CFG_W'(MAX_SIDE_LOG2)) begin
      r = SIDE_L;
    end else begin
      r = v[LW-1:0];
    end
    return r;
  endfunction

  function automatic logic [SIDE-1:0] rev_bits(input logic [SIDE-1:0] v);
    logic [SIDE-1:0] r;
    for (int i = 0; i < SIDE; i++) begin
      r[i] = v[SIDE-1-i];
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [whmr_pkg::CFG_W-1:0] width_log2_q, height_log2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_log2_q  <= whmr_pkg::CFG_LOG2_RESET;
      height_log2_q <= whmr_pkg::CFG_LOG2_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        whmr_pkg::CFG_WIDTH_LOG2:  width_log2_q  <= cfg_data_i;
        whmr_pkg::CFG_HEIGHT_LOG2: height_log2_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Handshake chain: s0 (index) -> s1 (row sequencer) -> p1 -> p2 (output)
  // --------------------------------------------------------------------------
  logic s0_valid_q, s1_valid_q, p1_valid_q, p2_valid_q;
  logic p2_ready, p1_ready, issue, s1_last, s1_free, s0_move, in_ready;

  logic [whmr_pkg::IDX_W-1:0] s0_idx_q;

  logic [SIDE-1:0]           ry_q, hmask_q, y_q;
  logic [whmr_pkg::ROW_W-1:0] base_q, wmask_q;

  logic [SIDE-1:0]            p1_y_q;
  logic                       p1_last_q, p1_py_q;
  logic [whmr_pkg::ROW_W-1:0] p1_base_q, p1_wmask_q;

  logic [SIDE-1:0]            p2_y_q;
  logic                       p2_last_q;
  logic [whmr_pkg::ROW_W-1:0] p2_row_q;

  assign p2_ready = !p2_valid_q || out_o.ready;
  assign p1_ready = !p1_valid_q || p2_ready;
  assign issue    = s1_valid_q && p1_ready;
  assign s1_last  = (y_q == hmask_q);
  assign s1_free  = !s1_valid_q || (p1_ready && s1_last);
  assign s0_move  = s0_valid_q && s1_free;
  assign in_ready = !s0_valid_q || s1_free;

  assign in_i.ready = in_ready;

  // --------------------------------------------------------------------------
  // s0 -> s1 item setup: split, Gray-code, reverse, column base row
  // --------------------------------------------------------------------------
  logic [LW-1:0]              wl, hl;
  logic [whmr_pkg::IDX_W-1:0] sx, sy, gx, gy;
  logic [SIDE-1:0]            rx, ry, hmask;
  logic [whmr_pkg::ROW_W-1:0] base, wmask;

  always_comb begin
    wl    = clamp_log2(width_log2_q);
    hl    = clamp_log2(height_log2_q);
    sx    = s0_idx_q & ~({whmr_pkg::IDX_W{1'b1}} << wl);
    sy    = s0_idx_q >> wl;
    gx    = sx ^ (sx >> 1);
    gy    = sy ^ (sy >> 1);
    hmask = {SIDE{1'b1}} >> (SIDE_L - hl);
    // reversing the full field then shifting down reverses the low bits only
    rx    = rev_bits(gx[SIDE-1:0]) >> (SIDE_L - wl);
    ry    = rev_bits(gy[SIDE-1:0] & hmask) >> (SIDE_L - hl);
    for (int x = 0; x < whmr_pkg::ROW_W; x++) begin
      if ((x < (1 << SIDE)) && ((x >> wl) == 0)) begin
        wmask[x] = 1'b1;
        base[x]  = ~(^(rx & x[SIDE-1:0]));
      end else begin
        wmask[x] = 1'b0;
        base[x]  = 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
      s1_valid_q <= 1'b0;
      p1_valid_q <= 1'b0;
      p2_valid_q <= 1'b0;
      y_q        <= '0;
    end else begin
      if (in_ready) begin
        s0_valid_q <= in_i.valid;
      end
      if (s1_free) begin
        s1_valid_q <= s0_valid_q;
      end
      if (s0_move) begin
        y_q <= '0;
      end else if (issue) begin
        y_q <= y_q + 1'b1;
      end
      if (p1_ready) begin
        p1_valid_q <= issue;
      end
      if (p2_ready) begin
        p2_valid_q <= p1_valid_q;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_ready) begin
      s0_idx_q <= in_i.mask_index;
    end
    if (s0_move) begin
      ry_q    <= ry;
      hmask_q <= hmask;
      base_q  <= base;
      wmask_q <= wmask;
    end
    if (issue) begin
      p1_y_q     <= y_q;
      p1_last_q  <= s1_last;
      p1_py_q    <= ^(ry_q & y_q);
      p1_base_q  <= base_q;
      p1_wmask_q <= wmask_q;
    end
    if (p2_ready && p1_valid_q) begin
      // odd row parity flips every in-range pixel
      p2_row_q  <= p1_base_q ^ ({whmr_pkg::ROW_W{p1_py_q}} & p1_wmask_q);
      p2_y_q    <= p1_y_q;
      p2_last_q <= p1_last_q;
    end
  end

  assign out_o.valid      = p2_valid_q;
  assign out_o.row_bits   = p2_row_q;
  assign out_o.row_number = whmr_pkg::ROW_NUM_W'(p2_y_q);
  assign out_o.last_row   = p2_last_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // An accepted index beat is held in s0 next cycle.
  a_in_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> s0_valid_q)
    else $error("accepted index beat not captured");

  // A freshly loaded item starts at row 0.
  a_row_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s0_move |=> (s1_valid_q && (y_q == '0)))
    else $error("row sequencer did not restart at row 0");

  // Rows advance by one per issue until the last one.
  a_row_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (issue && !s1_last) |=> (s1_valid_q && (y_q == $past(y_q) + 1'b1)))
    else $error("row sequencer skipped or repeated a row");

endmodule
`default_nettype wire
